// ===== src/mcwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Watchdog table package
// Request, result and table entry types, operation and status codes.
// ----------------------------------------------------------------------------
package mcwt_pkg;

    localparam int ID_W     = 22;
    localparam int TAG_W    = 16;
    localparam int PERIOD_W = 16;
    localparam int TIME_W   = 32;
    localparam int MISS_W   = 8;
    localparam int PROD_W   = MISS_W + PERIOD_W;

    localparam int MAX_RESULTS = 16;
    localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_FEED       = 2'd1;
    localparam logic [1:0] OP_UNREGISTER = 2'd2;
    localparam logic [1:0] OP_TICK       = 2'd3;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_REG_FAIL   = 2'd1;
    localparam logic [1:0] STAT_FEED_FAIL  = 2'd2;
    localparam logic [1:0] STAT_UNREG_FAIL = 2'd3;

    localparam logic CFG_MAX_MISSED     = 1'b0;
    localparam logic CFG_DEFAULT_PERIOD = 1'b1;

    typedef struct packed {
        logic [1:0]          operation;
        logic [ID_W-1:0]     client_id;
        logic [TAG_W-1:0]    name_tag;
        logic [PERIOD_W-1:0] feed_period;
        logic [TIME_W-1:0]   now_secs;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             expired;
        logic [ID_W-1:0]  expired_id;
        logic [TAG_W-1:0] expired_tag;
        logic             last_of_run;
    } res_t;

    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     id;
        logic [TAG_W-1:0]    tag;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   last_feed;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic append;
        logic update;
        logic feed;
    } cell_ctrl_t;

endpackage

// ===== src/mcwt_cell.sv =====
// ----------------------------------------------------------------------------
// Watchdog table cell
// One table entry; loads from its upper neighbour, appends, updates or
// refreshes, and flags id and tag matches against the current request.
// ----------------------------------------------------------------------------
module mcwt_cell import mcwt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     nb,
    input  req_t       req,
    output entry_t     ent,
    output logic       id_hit,
    output logic       tag_hit
);

    logic                valid_reg;
    logic [ID_W-1:0]     id_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W-1:0]   last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= nb.valid;
        end
        else if (ctrl.append)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            id_reg     <= nb.id;
            tag_reg    <= nb.tag;
            period_reg <= nb.period;
            last_reg   <= nb.last_feed;
        end
        else if (ctrl.append)
        begin
            id_reg     <= req.client_id;
            tag_reg    <= req.name_tag;
            period_reg <= req.feed_period;
            last_reg   <= req.now_secs;
        end
        else if (ctrl.update)
        begin
            // tag stays as first registered
            id_reg     <= req.client_id;
            period_reg <= req.feed_period;
            last_reg   <= req.now_secs;
        end
        else if (ctrl.feed)
        begin
            last_reg <= req.now_secs;
        end
    end

    assign ent.valid     = valid_reg;
    assign ent.id        = id_reg;
    assign ent.tag       = tag_reg;
    assign ent.period    = period_reg;
    assign ent.last_feed = last_reg;

    assign id_hit  = valid_reg && (id_reg == req.client_id);
    assign tag_hit = valid_reg && (tag_reg == req.name_tag);

endmodule

// ===== src/mcwt_check.sv =====
// ----------------------------------------------------------------------------
// Watchdog deadline check
// Registers max_missed * period for the entry about to reach the head, then
// compares the wide deadline against the current time.
// ----------------------------------------------------------------------------
module mcwt_check import mcwt_pkg::*;
(
    input  logic                clk,
    input  logic [MISS_W-1:0]   max_missed,
    input  logic [PERIOD_W-1:0] next_period,
    input  logic [TIME_W-1:0]   last_feed,
    input  logic [TIME_W-1:0]   now_secs,
    output logic                expire
);

    logic [PROD_W-1:0] prod_reg;
    logic [TIME_W:0]   deadline;

    always_ff @(posedge clk)
    begin
        prod_reg <= max_missed * next_period;
    end

    assign deadline = {1'b0, last_feed} + {{(TIME_W + 1 - PROD_W){1'b0}}, prod_reg};
    assign expire   = {1'b0, now_secs} > deadline;

endmodule

// ===== src/multi_client_watchdog_table.sv =====
// ----------------------------------------------------------------------------
// Multi-client watchdog table
// Register, feed and unregister are worked in S_EXEC, busy while there, the
// result strobe rising as busy falls. A tick rotates the whole ring of SLOTS
// cells past one deadline checker, busy through S_PRIME, S_SCAN and S_FLUSH:
// one result per expired entry, up to MAX_RESULTS, the last marked last_of_run
// and given as busy falls, also when none expired. Results cannot be stalled.
// Reset empties the table; max_missed is 3 and default_period is 10.
// ----------------------------------------------------------------------------
module multi_client_watchdog_table import mcwt_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        result_strobe,
    output res_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int NEXT  = (SLOTS > 1) ? 1 : 0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PRIME,
        S_SCAN,
        S_FLUSH
    } state_t;

    // configuration
    logic [MISS_W-1:0]   max_missed_reg;
    logic [PERIOD_W-1:0] default_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_missed_reg     <= MISS_W'(3);
            default_period_reg <= PERIOD_W'(10);
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                CFG_MAX_MISSED:     max_missed_reg     <= pwdata[MISS_W-1:0];
                CFG_DEFAULT_PERIOD: default_period_reg <= pwdata[PERIOD_W-1:0];
                default:            max_missed_reg     <= max_missed_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            CFG_MAX_MISSED:     prdata = {{(32 - MISS_W){1'b0}}, max_missed_reg};
            CFG_DEFAULT_PERIOD: prdata = {{(32 - PERIOD_W){1'b0}}, default_period_reg};
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // control state
    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [FOUND_W-1:0] found_reg, found_next;
    res_t               pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    res_t               result_reg, result_next;
    logic               strobe_reg, strobe_next;

    // cell ring
    entry_t     ents [SLOTS];
    cell_ctrl_t ctrl [SLOTS];
    logic       id_hit [SLOTS];
    logic       tag_hit [SLOTS];
    entry_t     tail_in;

    logic [SLOTS-1:0] first_m;
    logic [SLOTS-1:0] first_id;
    logic [SLOTS-1:0] from_id;
    logic             any_m;
    logic             any_id;
    logic             full;
    logic             expire;
    logic             hit;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        entry_t nb;
        if (g == SLOTS - 1)
        begin : g_tail
            assign nb = tail_in;
        end
        else
        begin : g_body
            assign nb = ents[g+1];
        end

        mcwt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[g]),
            .nb      (nb),
            .req     (req_reg),
            .ent     (ents[g]),
            .id_hit  (id_hit[g]),
            .tag_hit (tag_hit[g])
        );
    end

    mcwt_check u_check (
        .clk         (clk),
        .max_missed  (max_missed_reg),
        .next_period ((state_reg == S_SCAN) ? ents[NEXT].period : ents[0].period),
        .last_feed   (ents[0].last_feed),
        .now_secs    (req_reg.now_secs),
        .expire      (expire)
    );

    assign hit  = expire && ents[0].valid && (found_reg < FOUND_W'(MAX_RESULTS));
    assign full = (count_reg == CNT_W'(SLOTS));

    // first-match search along the ring
    always_comb
    begin
        logic seen_m;
        logic seen_id;
        seen_m  = 1'b0;
        seen_id = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            first_m[i]  = (id_hit[i] || tag_hit[i]) && !seen_m;
            seen_m      = seen_m || id_hit[i] || tag_hit[i];
            first_id[i] = id_hit[i] && !seen_id;
            seen_id     = seen_id || id_hit[i];
            from_id[i]  = seen_id;
        end
        any_m  = seen_m;
        any_id = seen_id;
    end

    // rotate the head round during a tick; close the gap on unregister
    always_comb
    begin
        tail_in = ents[0];
        if (state_reg == S_SCAN)
        begin
            if (hit)
            begin
                tail_in.last_feed = req_reg.now_secs;
            end
        end
        else
        begin
            tail_in.valid = 1'b0;
        end
    end

    always_comb
    begin
        logic exec;
        exec = (state_reg == S_EXEC);
        for (int i = 0; i < SLOTS; i++)
        begin
            ctrl[i].shift  = (state_reg == S_SCAN)
                          || (exec && req_reg.operation == OP_UNREGISTER && from_id[i]);
            ctrl[i].append = exec && req_reg.operation == OP_REGISTER && !any_m && !full
                          && (count_reg == CNT_W'(i));
            ctrl[i].update = exec && req_reg.operation == OP_REGISTER && first_m[i];
            ctrl[i].feed   = exec && req_reg.operation == OP_FEED && first_id[i];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        result_next     = '0;
        strobe_next     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    if (request.feed_period == '0)
                    begin
                        req_next.feed_period = default_period_reg;
                    end
                    state_next = (request.operation == OP_TICK) ? S_PRIME : S_EXEC;
                end
            end
            S_EXEC:
            begin
                result_next.last_of_run = 1'b1;
                strobe_next             = 1'b1;
                case (req_reg.operation)
                    OP_REGISTER:
                    begin
                        if (!any_m && full)
                        begin
                            result_next.status = STAT_REG_FAIL;
                        end
                        else if (!any_m)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_FEED:
                    begin
                        if (!any_id)
                        begin
                            result_next.status = STAT_FEED_FAIL;
                        end
                    end
                    OP_UNREGISTER:
                    begin
                        if (!any_id)
                        begin
                            result_next.status = STAT_UNREG_FAIL;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        result_next.status = STAT_OK;
                    end
                endcase
                state_next = S_IDLE;
            end
            S_PRIME:
            begin
                scan_next       = '0;
                found_next      = '0;
                pend_valid_next = 1'b0;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    // hold each hit until the next one shows it was not the last
                    if (pend_valid_reg)
                    begin
                        result_next = pend_reg;
                        strobe_next = 1'b1;
                    end
                    pend_next             = '0;
                    pend_next.expired     = 1'b1;
                    pend_next.expired_id  = ents[0].id;
                    pend_next.expired_tag = ents[0].tag;
                    pend_valid_next       = 1'b1;
                    found_next            = found_reg + FOUND_W'(1);
                end
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg == CNT_W'(SLOTS - 1))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    result_next = pend_reg;
                end
                result_next.last_of_run = 1'b1;
                strobe_next             = 1'b1;
                pend_valid_next         = 1'b0;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            count_reg      <= '0;
            scan_reg       <= '0;
            found_reg      <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            result_reg     <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            found_reg      <= found_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            result_reg     <= result_next;
            strobe_reg     <= strobe_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule
